// ===== rtl/fba_pkg.sv =====
// ----------------------------------------------------------------------------
// fba_pkg: shared types and constants of the frame bitmap allocator
// Action codes, word geometry and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none
package fba_pkg;
	localparam int unsigned MAX_FRAMES = 4096;
	localparam int unsigned MAX_RUN   = 64;
	localparam int unsigned WORD_BITS = 32;
	localparam int unsigned WBIT_W    = 5;
	localparam int unsigned LIMIT_W   = 13;
	localparam int unsigned ADDR_W    = 39;
	localparam int unsigned OFFSET_W  = 12;
	localparam int unsigned INDEX_W   = 12;
	localparam int unsigned ACTION_W  = 3;
	localparam int unsigned RUNLEN_W  = 7;

	typedef enum logic [ACTION_W-1:0] {
		ACT_LOCK    = 3'd0,
		ACT_RELEASE = 3'd1,
		ACT_PROBE   = 3'd2,
		ACT_ALLOC1  = 3'd3,
		ACT_ALLOCN  = 3'd4,
		ACT_FIND1   = 3'd5,
		ACT_RSVD6   = 3'd6,
		ACT_RSVD7   = 3'd7
	} action_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_SCAN,
		ST_WRITE,
		ST_DONE
	} state_t;
endpackage
`default_nettype wire

// ===== rtl/fba_mem.sv =====
// ----------------------------------------------------------------------------
// fba_mem: bitmap word store
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module fba_mem #(
	parameter int unsigned DEPTH = 128,
	parameter int unsigned AW    = 7
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [31:0]   wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [31:0]   rdata
);
	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/frame_bitmap_allocator.sv =====
// ----------------------------------------------------------------------------
// frame_bitmap_allocator: bitmap physical frame allocator
// Busy bitmap in a word memory plus lowest-free hint; lock, release, probe,
// find/allocate one, allocate run.
// ----------------------------------------------------------------------------
//  channel | signals                                   | dir
//  in      | in_valid in_ready action phys_address run_length | sink
//  out     | out_valid out_ready frame_index found busy_res  | source
//  cfg     | cfg_we cfg_wdata (frame_limit)             | sink
//
// After reset a clearing pass writes all-ones to every word before the first
// item is taken.
// Lock/release/probe: a read wait, then the modify, then the result.
// Find/allocate one: each word from the hint word is read, then tested.
// Allocate run: one frame per cycle plus one read wait per word crossed,
// then a read and a write per word locked.
// One item at a time; in_ready is low from accept until the result is taken.
`default_nettype none
module frame_bitmap_allocator (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [fba_pkg::LIMIT_W-1:0]   cfg_wdata,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [fba_pkg::ACTION_W-1:0]  action,
	input  wire logic [fba_pkg::ADDR_W-1:0]    phys_address,
	input  wire logic [fba_pkg::RUNLEN_W-1:0]  run_length,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [fba_pkg::INDEX_W-1:0]        frame_index,
	output logic                               found,
	output logic                               busy_res
);
	import fba_pkg::*;

	localparam int unsigned WORDS = MAX_FRAMES / 32;
	localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int unsigned FW    = $clog2(MAX_FRAMES) + 1; // holds MAX_FRAMES
	localparam int unsigned WCW   = AW + 1;                  // holds WORDS

	state_t state_q, state_d;

	logic [LIMIT_W-1:0] limit_q;
	logic [FW-1:0]      hint_q;
	logic [ACTION_W-1:0] act_q;
	logic [FW-1:0]      frame_q;     // target frame or scan position
	logic [RUNLEN_W-1:0] len_q;
	logic [FW-1:0]      cnt_q;       // run count
	logic [RUNLEN_W:0]  left_q;      // frames still to lock
	logic [WCW-1:0]     word_q;      // word being read
	logic               rd_pend_q;   // read issued last cycle
	logic [31:0]        wdat_q;
	logic [AW-1:0]      waddr_q;
	logic               we_q;
	logic [INDEX_W-1:0] res_idx_q;
	logic               res_found_q, res_busy_q;

	logic [31:0]  rdata;
	logic [AW-1:0] raddr;

	// active limit = min(limit, MAX_FRAMES)
	logic [FW-1:0] lim;
	always_comb begin
		if (limit_q > LIMIT_W'(MAX_FRAMES))
			lim = FW'(MAX_FRAMES);
		else
			lim = FW'(limit_q);
	end
	logic [WCW-1:0] end_word;
	assign end_word = WCW'(lim >> 5);

	fba_mem #(.DEPTH(WORDS), .AW(AW)) u_mem (
		.clk   (clk),
		.we    (we_q),
		.waddr (waddr_q),
		.wdata (wdat_q),
		.raddr (raddr),
		.rdata (rdata)
	);
	assign raddr = word_q[AW-1:0];

	// first clear bit of the read word
	logic        any_free;
	logic [4:0]  first_free;
	always_comb begin
		any_free   = 1'b0;
		first_free = '0;
		for (int b = 31; b >= 0; b--) begin
			if (!rdata[b]) begin
				any_free   = 1'b1;
				first_free = 5'(b);
			end
		end
	end

	logic [FW-1:0] addr_frame;
	assign addr_frame = (phys_address[ADDR_W-1:OFFSET_W] >= (ADDR_W-OFFSET_W)'(MAX_FRAMES))
		? FW'(MAX_FRAMES) : FW'(phys_address[ADDR_W-1:OFFSET_W]);

	logic frame_ok;
	assign frame_ok = frame_q < lim;
	logic [4:0] fbit;
	assign fbit = frame_q[4:0];
	logic [FW-1:0] lenx;
	assign lenx = FW'(len_q);

	// run lock: bits fbit and up in this word, at most left_q of them
	logic [5:0]  room;
	logic [5:0]  take;
	logic [31:0] lock_mask;
	assign room      = 6'd32 - {1'b0, fbit};
	assign take      = (left_q < (RUNLEN_W+1)'(room)) ? left_q[5:0] : room;
	assign lock_mask = (~(32'hFFFF_FFFF << take)) << fbit;

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_DONE);
	assign frame_index = res_idx_q;
	assign found = res_found_q;
	assign busy_res = res_busy_q;

	// run scan: one frame per cycle inside the word read, bit position fbit
	logic bit_busy;
	assign bit_busy = rdata[fbit] || !frame_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			limit_q     <= LIMIT_W'(4096);
			hint_q      <= '0;
			word_q      <= '0;
			we_q        <= 1'b0;
			rd_pend_q   <= 1'b0;
			res_found_q <= 1'b0;
			res_busy_q  <= 1'b0;
			res_idx_q   <= '0;
		end else begin
			state_q   <= state_d;
			we_q      <= 1'b0;
			rd_pend_q <= 1'b0;
			if (cfg_we) limit_q <= cfg_wdata;
			case (state_q)
				ST_CLEAR: begin
					we_q    <= 1'b1;
					waddr_q <= word_q[AW-1:0];
					wdat_q  <= '1;
					word_q  <= word_q + 1'b1;
				end
				ST_IDLE: begin
					if (in_valid) begin
						act_q      <= action;
						len_q      <= run_length;
						cnt_q      <= '0;
						res_found_q <= 1'b0;
						res_busy_q <= 1'b0;
						res_idx_q  <= '0;
						if (action == ACT_ALLOC1 || action == ACT_FIND1
							|| action == ACT_ALLOCN) begin
							frame_q <= hint_q;
							word_q  <= WCW'(hint_q >> 5);
						end else begin
							frame_q <= addr_frame;
							word_q  <= WCW'(addr_frame >> 5);
						end
						rd_pend_q <= 1'b1;
					end
				end
				ST_READ: begin
					if (!rd_pend_q) begin
						// rdata valid for word_q
						case (act_q)
							ACT_LOCK: begin
								if (frame_ok) begin
									we_q <= 1'b1;
									waddr_q <= word_q[AW-1:0];
									wdat_q <= rdata | (32'd1 << fbit);
								end
							end
							ACT_RELEASE: begin
								if (frame_ok) begin
									we_q <= 1'b1;
									waddr_q <= word_q[AW-1:0];
									wdat_q <= rdata & ~(32'd1 << fbit);
									if (frame_q < hint_q) hint_q <= frame_q;
								end
							end
							ACT_PROBE: res_busy_q <= bit_busy;
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					if (act_q == ACT_ALLOCN) begin
						if (rd_pend_q) begin
							// waiting on the read of word_q
						end else if (frame_q >= lim || len_q == '0
							|| len_q > RUNLEN_W'(MAX_RUN)) begin
							// miss
						end else begin
							if (bit_busy) cnt_q <= '0;
							else if (cnt_q + 1'b1 == lenx) begin
								res_found_q <= 1'b1;
								res_idx_q   <= INDEX_W'(frame_q + 1'b1 - lenx);
								frame_q     <= frame_q + 1'b1 - lenx;
								word_q      <= WCW'((frame_q + 1'b1 - lenx) >> 5);
								left_q      <= (RUNLEN_W+1)'(len_q);
								rd_pend_q   <= 1'b1;
							end else cnt_q <= cnt_q + 1'b1;
							if (!(!bit_busy && cnt_q + 1'b1 == lenx)) begin
								frame_q <= frame_q + 1'b1;
								if (fbit == 5'd31) begin
									word_q    <= word_q + 1'b1;
									rd_pend_q <= 1'b1;
								end
							end
						end
					end else begin
						if (rd_pend_q) begin
						end else if (word_q >= end_word) begin
						end else if (any_free) begin
							res_found_q <= 1'b1;
							res_idx_q   <= INDEX_W'({word_q[AW-1:0], first_free});
							hint_q      <= FW'({word_q[AW-1:0], first_free});
							if (act_q == ACT_ALLOC1) begin
								we_q    <= 1'b1;
								waddr_q <= word_q[AW-1:0];
								wdat_q  <= rdata | (32'd1 << first_free);
							end
						end else begin
							word_q    <= word_q + 1'b1;
							rd_pend_q <= 1'b1;
						end
					end
				end
				ST_WRITE: begin
					// lock run: one word per visit, read then write
					if (!rd_pend_q) begin
						we_q    <= 1'b1;
						waddr_q <= word_q[AW-1:0];
						wdat_q  <= rdata | lock_mask;
						left_q  <= left_q - (RUNLEN_W+1)'(take);
						frame_q <= FW'({word_q + 1'b1, 5'd0});
						word_q  <= word_q + 1'b1;
						rd_pend_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	logic scan_done;
	always_comb begin
		scan_done = 1'b0;
		if (!rd_pend_q) begin
			if (act_q == ACT_ALLOCN)
				scan_done = frame_q >= lim || len_q == '0 || len_q > RUNLEN_W'(MAX_RUN)
					|| (!bit_busy && cnt_q + 1'b1 == lenx);
			else
				scan_done = word_q >= end_word || any_free;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (word_q == WCW'(WORDS - 1)) state_d = ST_IDLE;
			ST_IDLE:  if (in_valid) begin
				if (action == ACT_ALLOC1 || action == ACT_FIND1 || action == ACT_ALLOCN)
					state_d = ST_SCAN;
				else
					state_d = ST_READ;
			end
			ST_READ:  if (!rd_pend_q) state_d = ST_DONE;
			ST_SCAN: if (scan_done) begin
				if (act_q == ACT_ALLOCN && !(frame_q >= lim || len_q == '0
					|| len_q > RUNLEN_W'(MAX_RUN)) && !bit_busy)
					state_d = ST_WRITE;
				else
					state_d = ST_DONE;
			end
			ST_WRITE: if (!rd_pend_q && left_q <= (RUNLEN_W+1)'(room))
				state_d = ST_DONE;
			ST_DONE:  if (out_ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire
